// ===== hw/rtl/tce_pkg.sv =====
// Shared types and constants for the three-register execute core.
// Used by tce_exec, tce_ram users and the top level; no dependencies.
package tce_pkg;

    localparam int RAM_WORDS = 4096;   // power of two; addresses wrap
    localparam int RAM_AW    = $clog2(RAM_WORDS);
    localparam int WORD_W    = 16;

    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_LDI_A = 8'h01;
    localparam logic [7:0] OP_LDI_B = 8'h02;
    localparam logic [7:0] OP_LDI_C = 8'h03;
    localparam logic [7:0] OP_LD_A  = 8'h04;
    localparam logic [7:0] OP_LD_B  = 8'h05;
    localparam logic [7:0] OP_LD_C  = 8'h06;
    localparam logic [7:0] OP_ST_A  = 8'h07;
    localparam logic [7:0] OP_ST_B  = 8'h08;
    localparam logic [7:0] OP_ST_C  = 8'h09;
    localparam logic [7:0] OP_ADD   = 8'h0a;
    localparam logic [7:0] OP_SUB   = 8'h0b;
    localparam logic [7:0] OP_AND   = 8'h0c;
    localparam logic [7:0] OP_OR    = 8'h0d;
    localparam logic [7:0] OP_NOT   = 8'h0e;
    localparam logic [7:0] OP_NOR   = 8'h0f;
    localparam logic [7:0] OP_NAND  = 8'h10;
    localparam logic [7:0] OP_JMP   = 8'h11;
    localparam logic [7:0] OP_JZ    = 8'h12;
    localparam logic [7:0] OP_JF2   = 8'h13;
    localparam logic [7:0] OP_XOR   = 8'h14;
    localparam logic [7:0] OP_HALT  = 8'h15;
    localparam logic [7:0] OP_INB   = 8'h16;
    localparam logic [7:0] OP_OUTB  = 8'h17;
    localparam logic [7:0] OP_JNZ   = 8'h18;
    localparam logic [7:0] OP_LSL   = 8'h19;
    localparam logic [7:0] OP_LSR   = 8'h1a;

    localparam logic [1:0] REG_A = 2'd0;
    localparam logic [1:0] REG_B = 2'd1;
    localparam logic [1:0] REG_C = 2'd2;
    localparam logic [7:0] SEL_MAX = 8'd2;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } phase_t;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] regs;
        logic [WORD_W-1:0]      ip;
        logic [WORD_W-1:0]      out_latch;
        logic [WORD_W-1:0]      last_alu;
        logic                   zero_bit;
        logic                   stopped;
        logic                   faulted;
    } mach_state_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

endpackage

// ===== hw/rtl/three_register_cpu_execute_core.sv =====
// Top level of the three-register execute core.
// Depends on tce_pkg, tce_exec and tce_ram.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | opcode, src_sel, dst_sel, imm, in_bus
//  out     | out_valid / out_stall | next_ip, out_bus, alu_value, zero_flag,
//          |                       | halted, fault
//
// One beat per cycle sustained while out_stall is low, once the RAM clear is done.
// The input edge starts the synchronous RAM read; the instruction executes as
// the input register advances, loading the machine state, which is the output
// payload. After reset the RAM is zeroed one word a cycle, with in_stall high
// until all RAM_WORDS (4096) words are clear.
// Output stall backs up into the input register and then into in_stall.
module three_register_cpu_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  opcode,
    input  logic [7:0]  src_sel,
    input  logic [7:0]  dst_sel,
    input  logic [15:0] imm,
    input  logic [15:0] in_bus,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_ip,
    output logic [15:0] out_bus,
    output logic [15:0] alu_value,
    output logic        zero_flag,
    output logic        halted,
    output logic        fault
);

    tce_pkg::phase_t              phase_reg, phase_next;
    logic [tce_pkg::RAM_AW-1:0]   clr_addr_reg, clr_addr_next;

    logic                         s1_valid_reg;
    logic [7:0]                   s1_opcode_reg;
    logic [7:0]                   s1_src_reg;
    logic [7:0]                   s1_dst_reg;
    logic [15:0]                  s1_imm_reg;
    logic [15:0]                  s1_in_bus_reg;
    logic                         fwd_hit_reg;
    logic [15:0]                  fwd_data_reg;

    logic                         out_valid_reg;
    tce_pkg::mach_state_t         state_reg;
    tce_pkg::mach_state_t         state_next;
    tce_pkg::ram_wr_t             exec_wr;

    logic                         advance;
    logic                         accept;
    logic                         clearing;
    logic                         ram_we;
    logic [tce_pkg::RAM_AW-1:0]   ram_waddr;
    logic [15:0]                  ram_wdata;
    logic [15:0]                  ram_rdata;
    logic [15:0]                  ld_data;

    assign clearing = (phase_reg == tce_pkg::PH_CLEAR);
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing || (s1_valid_reg && !advance);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tce_pkg::PH_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        clr_addr_next = clr_addr_reg;
        unique case (phase_reg)
            tce_pkg::PH_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    phase_next = tce_pkg::PH_RUN;
                end
            end
            tce_pkg::PH_RUN: ;
            default: phase_next = tce_pkg::PH_CLEAR;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input register; a store retiring on the same edge bypasses the RAM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg <= opcode;
            s1_src_reg    <= src_sel;
            s1_dst_reg    <= dst_sel;
            s1_imm_reg    <= imm;
            s1_in_bus_reg <= in_bus;
            fwd_hit_reg   <= advance && exec_wr.en
                             && (exec_wr.addr == imm[tce_pkg::RAM_AW-1:0]);
            fwd_data_reg  <= exec_wr.data;
        end
    end

    assign ld_data = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    tce_exec u_exec (
        .opcode   (s1_opcode_reg),
        .src_sel  (s1_src_reg),
        .dst_sel  (s1_dst_reg),
        .imm      (s1_imm_reg),
        .in_bus   (s1_in_bus_reg),
        .ram_data (ld_data),
        .cur      (state_reg),
        .nxt      (state_next),
        .wr       (exec_wr)
    );

    assign ram_we    = clearing || (advance && exec_wr.en);
    assign ram_waddr = clearing ? clr_addr_reg : exec_wr.addr;
    assign ram_wdata = clearing ? 16'd0 : exec_wr.data;

    tce_ram #(
        .WIDTH (tce_pkg::WORD_W),
        .DEPTH (tce_pkg::RAM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (imm[tce_pkg::RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign next_ip   = state_reg.ip;
    assign out_bus   = state_reg.out_latch;
    assign alu_value = state_reg.last_alu;
    assign zero_flag = state_reg.zero_bit;
    assign halted    = state_reg.stopped;
    assign fault     = state_reg.faulted;

endmodule

// ===== hw/rtl/tce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tce_exec.sv =====
// Combinational execute unit: one instruction against the machine state.
// Depends on tce_pkg.
module tce_exec (
    input  logic [7:0]                  opcode,
    input  logic [7:0]                  src_sel,
    input  logic [7:0]                  dst_sel,
    input  logic [15:0]                 imm,
    input  logic [15:0]                 in_bus,
    input  logic [15:0]                 ram_data,
    input  tce_pkg::mach_state_t        cur,
    output tce_pkg::mach_state_t        nxt,
    output tce_pkg::ram_wr_t            wr
);

    logic [15:0] x_val;
    logic [15:0] y_val;
    logic [15:0] alu_res;
    logic        sel_ok;
    logic        is_alu;
    logic        known;
    logic [15:0] ip_inc;

    assign sel_ok = (src_sel <= tce_pkg::SEL_MAX) && (dst_sel <= tce_pkg::SEL_MAX);
    assign x_val  = cur.regs[src_sel[1:0]];
    assign y_val  = cur.regs[dst_sel[1:0]];
    assign ip_inc = cur.ip + 16'd1;

    always_comb
    begin
        is_alu  = 1'b1;
        alu_res = '0;
        unique case (opcode)
            tce_pkg::OP_ADD:  alu_res = x_val + y_val;
            tce_pkg::OP_SUB:  alu_res = x_val - y_val;
            tce_pkg::OP_AND:  alu_res = x_val & y_val;
            tce_pkg::OP_OR:   alu_res = x_val | y_val;
            tce_pkg::OP_NOT:  alu_res = ~x_val | ~y_val;
            tce_pkg::OP_NOR:  alu_res = ~(x_val | y_val);
            tce_pkg::OP_NAND: alu_res = ~(x_val & y_val);
            tce_pkg::OP_XOR:  alu_res = x_val ^ y_val;
            tce_pkg::OP_LSL:  alu_res = {x_val[14:0], 1'b0} | {y_val[14:0], 1'b0};
            tce_pkg::OP_LSR:  alu_res = {1'b0, x_val[15:1]} | {1'b0, y_val[15:1]};
            default:          is_alu  = 1'b0;
        endcase
    end

    always_comb
    begin
        nxt     = cur;
        wr.en   = 1'b0;
        wr.addr = imm[tce_pkg::RAM_AW-1:0];
        wr.data = '0;
        known   = 1'b1;
        nxt.ip  = ip_inc;

        if (is_alu)
        begin
            if (sel_ok)
            begin
                nxt.regs[dst_sel[1:0]] = alu_res;
                nxt.last_alu           = alu_res;
                nxt.zero_bit           = (alu_res == 16'd0);
            end
        end
        else
        begin
            unique case (opcode)
                tce_pkg::OP_NOP: ;
                tce_pkg::OP_LDI_A: nxt.regs[tce_pkg::REG_A] = imm;
                tce_pkg::OP_LDI_B: nxt.regs[tce_pkg::REG_B] = imm;
                tce_pkg::OP_LDI_C: nxt.regs[tce_pkg::REG_C] = imm;
                tce_pkg::OP_LD_A:  nxt.regs[tce_pkg::REG_A] = ram_data;
                tce_pkg::OP_LD_B:  nxt.regs[tce_pkg::REG_B] = ram_data;
                tce_pkg::OP_LD_C:  nxt.regs[tce_pkg::REG_C] = ram_data;
                tce_pkg::OP_ST_A:
                begin
                    wr.en   = 1'b1;
                    wr.data = cur.regs[tce_pkg::REG_A];
                end
                tce_pkg::OP_ST_B:
                begin
                    wr.en   = 1'b1;
                    wr.data = cur.regs[tce_pkg::REG_B];
                end
                tce_pkg::OP_ST_C:
                begin
                    wr.en   = 1'b1;
                    wr.data = cur.regs[tce_pkg::REG_C];
                end
                tce_pkg::OP_JMP: nxt.ip = imm;
                tce_pkg::OP_JZ:
                begin
                    if (cur.zero_bit)
                    begin
                        nxt.ip = imm;
                    end
                end
                tce_pkg::OP_JF2: ;  // flag 2 never set
                tce_pkg::OP_HALT: nxt.stopped = 1'b1;
                tce_pkg::OP_INB:  nxt.regs[tce_pkg::REG_C] = in_bus;
                tce_pkg::OP_OUTB: nxt.out_latch = cur.regs[tce_pkg::REG_C];
                tce_pkg::OP_JNZ:
                begin
                    if (!cur.zero_bit)
                    begin
                        nxt.ip = imm;
                    end
                end
                default: known = 1'b0;
            endcase
        end

        if (!known)
        begin
            nxt         = cur;
            nxt.faulted = 1'b1;
            wr.en       = 1'b0;
        end

        // stopped or faulted machine ignores the beat
        if (cur.stopped || cur.faulted)
        begin
            nxt   = cur;
            wr.en = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/tce_checker.sv =====
// Port-level checks for three_register_cpu_execute_core, attached by bind.
// No package dependencies.
module tce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] next_ip,
    input logic        halted,
    input logic        fault
);

    // halt and fault are sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted |=> halted)
        else $error("halted dropped without reset");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault |=> fault)
        else $error("fault dropped without reset");

    // a stopped machine can never also fault
    a_halt_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(halted && fault))
        else $error("halted and fault both set");

    // pointer frozen once the machine is halted or faulted
    a_ip_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (halted || fault) |=> $stable(next_ip))
        else $error("next_ip moved on a stopped machine");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(next_ip)))
        else $error("stalled result beat changed");

endmodule

bind three_register_cpu_execute_core tce_checker u_tce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_ip   (next_ip),
    .halted    (halted),
    .fault     (fault)
);
